// ===== rtl/core/velocity_reflect_about_wall_unit_assert.svh =====
// Assertion macros for the velocity reflection unit.
// Clocked on clk and disabled while arst_n is low; no other dependencies.
`ifndef VELOCITY_REFLECT_ABOUT_WALL_UNIT_ASSERT_SVH
`define VELOCITY_REFLECT_ABOUT_WALL_UNIT_ASSERT_SVH

// Concurrent property checked at every rising clock edge outside reset.
`define VRW_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("velocity reflection unit: assertion failed");

// Same check with a message of its own.
`define VRW_ASSERT_MSG(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

`endif

// ===== rtl/core/vrw_pkg.sv =====
// Package for the velocity reflection unit: request and result types,
// CORDIC arctangent table and fixed-point constants. No dependencies.
`timescale 1ns / 1ps

package vrw_pkg;

	typedef struct packed {
		logic signed [15:0] speed_x;
		logic signed [15:0] speed_y;
		logic [15:0]        wall_angle;
		logic [15:0]        rect_width;
		logic [15:0]        rect_height;
	} item_t;

	typedef struct packed {
		logic signed [15:0] new_speed_x;
		logic signed [15:0] new_speed_y;
		logic [15:0]        new_heading;
	} result_t;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN         = 24;

	localparam int VEC_W   = 19;
	localparam int ROT_W   = 32;
	localparam int ANG_W   = 32;
	localparam int GAIN_W  = 31;
	localparam int PROD_W  = ROT_W + GAIN_W;
	localparam int FRAC_SH = 14;
	localparam int OUT_SH  = 44;
	localparam int RND_W   = PROD_W - OUT_SH;

	localparam logic [15:0] QUARTER_TURN = 16'h4000;
	localparam logic [ANG_W-1:0] HALF_TURN_A    = 32'h8000_0000;
	localparam logic [ANG_W-1:0] QUARTER_TURN_A = 32'h4000_0000;
	localparam logic [ANG_W-1:0] HEAD_ROUND     = 32'h0000_8000;

	localparam logic signed [GAIN_W-1:0] GAIN_INV   = 31'sd652032874;
	localparam logic signed [PROD_W-1:0] ROUND_BIAS = PROD_W'(64'sd1 <<< (OUT_SH - 1));

	localparam logic [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
	};

endpackage

// ===== rtl/core/velocity_reflect_about_wall_unit.sv =====
// Velocity reflection unit: reflects a Q8.8 velocity about a wall line.
// Depends on vrw_pkg and velocity_reflect_about_wall_unit_assert.svh.
//
// Usage:
// A request (item) carries the velocity, the wall angle and the wall
// rectangle extents; each request yields exactly one result carrying the
// reflected velocity and the new heading. Both channels use valid/ready.
// The datapath is a pipeline of CORDIC_STAGES + 3 registers: an input
// preparation stage, one stage per CORDIC iteration (rotation and
// vectoring run side by side), a gain multiply stage and the rounding and
// saturation stage that also serves as the output register.
// A result is offered once its request has passed through every stage, and
// a new request can be taken in every cycle in which the pipeline is not
// held, so throughput is one request per clock while nothing stalls.
// When the receiver holds result_ready low while a result is offered, the
// whole pipeline holds and item_ready falls in the same cycle; nothing is
// dropped or repeated. Reset clears every valid bit, so the pipeline
// comes out of reset empty and ready.
`timescale 1ns / 1ps
`include "velocity_reflect_about_wall_unit_assert.svh"

module velocity_reflect_about_wall_unit #(
	parameter int CORDIC_STAGES = vrw_pkg::CORDIC_STAGES_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_ready,
	input  vrw_pkg::item_t  item,
	output logic            result_valid,
	input  logic            result_ready,
	output vrw_pkg::result_t result
);

	localparam int N     = CORDIC_STAGES;
	localparam int VW    = vrw_pkg::VEC_W;
	localparam int RW    = vrw_pkg::ROT_W;
	localparam int AW    = vrw_pkg::ANG_W;
	localparam int PW    = vrw_pkg::PROD_W;
	localparam int NDW   = vrw_pkg::RND_W;
	localparam int LAST  = N + 2;
	localparam logic signed [AW:0] RES_LIM = (AW + 1)'(vrw_pkg::ATAN_TAB[N - 1]) <<< 1;

	logic [LAST:0] vld_q;
	logic          adv;

	logic signed [VW-1:0] vx_s [N+1];
	logic signed [VW-1:0] vy_s [N+1];
	logic [AW-1:0]        vz_s [N+1];
	logic signed [RW-1:0] rx_s [N+1];
	logic signed [RW-1:0] ry_s [N+1];
	logic [AW-1:0]        ra_s [N+1];
	logic [15:0]          wall_s [N+1];
	logic                 zero_s [N+1];

	logic signed [PW-1:0] prod_x_sm;
	logic signed [PW-1:0] prod_y_sm;
	logic [15:0]          head_sm;

	vrw_pkg::result_t result_q;

	logic [15:0]          wall_c;
	logic                 vneg_c;
	logic signed [VW-1:0] vx0_c;
	logic signed [VW-1:0] vy0_c;
	logic signed [RW-1:0] rx0_c;
	logic signed [RW-1:0] ry0_c;
	logic [AW-1:0]        ra0_c;
	logic [AW-1:0]        rchk_c;
	logic [AW-1:0]        hsum_c;
	logic [15:0]          head_in_c;
	logic signed [NDW-1:0] rnd_x_c;
	logic signed [NDW-1:0] rnd_y_c;
	logic signed [AW:0]   ra_last_c;

	assign result_valid = vld_q[LAST];
	assign adv          = !result_valid || result_ready;
	assign item_ready   = adv;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAST-1:0], item_valid};
		end
	end

	// Input preparation: wall direction, half-plane folding for the vectoring
	// path and half-turn reduction for the rotation path.
	always_comb begin
		wall_c = item.wall_angle;
		if (item.rect_width > item.rect_height) begin
			wall_c = item.wall_angle + vrw_pkg::QUARTER_TURN;
		end
		vneg_c = item.speed_x[15];
		vx0_c  = VW'(item.speed_x);
		vy0_c  = VW'(item.speed_y);
		if (vneg_c) begin
			vx0_c = -vx0_c;
			vy0_c = -vy0_c;
		end
		rx0_c  = RW'(item.speed_x) <<< vrw_pkg::FRAC_SH;
		ry0_c  = -(RW'(item.speed_y) <<< vrw_pkg::FRAC_SH);
		ra0_c  = {wall_c[14:0], 17'b0};
		rchk_c = ra0_c + vrw_pkg::QUARTER_TURN_A;
		if (rchk_c[AW-1]) begin
			rx0_c = -rx0_c;
			ry0_c = -ry0_c;
			ra0_c = ra0_c ^ vrw_pkg::HALF_TURN_A;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vx_s[0]   <= vx0_c;
			vy_s[0]   <= vy0_c;
			vz_s[0]   <= vneg_c ? vrw_pkg::HALF_TURN_A : '0;
			rx_s[0]   <= rx0_c;
			ry_s[0]   <= ry0_c;
			ra_s[0]   <= ra0_c;
			wall_s[0] <= wall_c;
			zero_s[0] <= (item.speed_x == '0) && (item.speed_y == '0);
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		always_ff @(posedge clk) begin
			if (adv) begin
				if (vy_s[i][VW-1]) begin
					vx_s[i+1] <= vx_s[i] - (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] + (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] - vrw_pkg::ATAN_TAB[i];
				end else begin
					vx_s[i+1] <= vx_s[i] + (vy_s[i] >>> i);
					vy_s[i+1] <= vy_s[i] - (vx_s[i] >>> i);
					vz_s[i+1] <= vz_s[i] + vrw_pkg::ATAN_TAB[i];
				end
				if (ra_s[i][AW-1]) begin
					rx_s[i+1] <= rx_s[i] + (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] - (rx_s[i] >>> i);
					ra_s[i+1] <= ra_s[i] + vrw_pkg::ATAN_TAB[i];
				end else begin
					rx_s[i+1] <= rx_s[i] - (ry_s[i] >>> i);
					ry_s[i+1] <= ry_s[i] + (rx_s[i] >>> i);
					ra_s[i+1] <= ra_s[i] - vrw_pkg::ATAN_TAB[i];
				end
				wall_s[i+1] <= wall_s[i];
				zero_s[i+1] <= zero_s[i];
			end
		end
	end

	assign hsum_c    = vz_s[N] + vrw_pkg::HEAD_ROUND;
	assign head_in_c = zero_s[N] ? 16'h0000 : hsum_c[AW-1:AW-16];

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_x_sm <= PW'(rx_s[N]) * PW'(vrw_pkg::GAIN_INV);
			prod_y_sm <= PW'(ry_s[N]) * PW'(vrw_pkg::GAIN_INV);
			head_sm   <= {wall_s[N][14:0], 1'b0} - head_in_c;
		end
	end

	assign rnd_x_c = NDW'((prod_x_sm + vrw_pkg::ROUND_BIAS) >>> vrw_pkg::OUT_SH);
	assign rnd_y_c = NDW'((prod_y_sm + vrw_pkg::ROUND_BIAS) >>> vrw_pkg::OUT_SH);

	function automatic logic signed [15:0] sat16(input logic signed [NDW-1:0] v);
		logic signed [15:0] r;
		r = v[15:0];
		if (v[NDW-1:15] != {(NDW - 15){v[NDW-1]}}) begin
			r = v[NDW-1] ? 16'sh8000 : 16'sh7FFF;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q.new_speed_x <= sat16(rnd_x_c);
			result_q.new_speed_y <= sat16(rnd_y_c);
			result_q.new_heading <= head_sm;
		end
	end

	assign ra_last_c = (AW + 1)'($signed(ra_s[N]));

	`VRW_ASSERT(a_hold_on_stall, !adv |=> $stable(vld_q))
	`VRW_ASSERT_MSG(a_zero_vector, vld_q[N] && zero_s[N] |-> rx_s[N] == '0 && ry_s[N] == '0,
		"zero velocity produced a non-zero rotated vector")
	`VRW_ASSERT_MSG(a_vec_x_nonneg, vld_q[N] |-> !vx_s[N][VW-1],
		"vectoring x component went negative")
	`VRW_ASSERT_MSG(a_rot_converged, vld_q[N] |-> ra_last_c <= RES_LIM && ra_last_c >= -RES_LIM,
		"rotation angle residual out of range")

endmodule
